>>> hw/rtl/phvts_pkg.sv
package phvts_pkg;

    localparam int TEXT_CAPACITY_DEF  = 1024;
    localparam int IMAGE_CAPACITY_DEF = 32768;
    localparam int PACKET_MAX_DEF     = 65535;
    localparam int HDR_BYTES          = 24;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [7:0] MAGIC_0 = 8'h47;
    localparam logic [7:0] MAGIC_1 = 8'h56;

    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_IMAGE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_MAGIC     = 3'd2;
    localparam logic [2:0] ERR_LENGTH    = 3'd3;
    localparam logic [2:0] ERR_SECTIONS  = 3'd4;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [14:0] index;
        logic [7:0]  data;
        logic [2:0]  error_code;
        logic [7:0]  peer_status;
        logic [9:0]  text_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] num_lines;
        logic [31:0] image_length;
        logic [15:0] packet_length;
        logic        last;
    } out_t;

    typedef struct packed {
        logic        has_data;
        logic [1:0]  data_kind;
        logic [14:0] data_index;
        logic [7:0]  data_byte;
        logic        has_status;
        logic [2:0]  error_code;
        logic [7:0]  peer_status;
        logic [9:0]  text_length;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] num_lines;
        logic [31:0] image_length;
        logic [15:0] packet_length;
    } op_t;

    function automatic logic [7:0] sanitize(input logic [7:0] c);
        if (c == 8'd13 || c == 8'd10) begin
            return 8'd10;
        end else if (c < 8'd32 || c > 8'd126) begin
            return 8'd32;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/phvts_front.sv
module phvts_front #(
    parameter int TEXT_CAPACITY  = phvts_pkg::TEXT_CAPACITY_DEF,
    parameter int IMAGE_CAPACITY = phvts_pkg::IMAGE_CAPACITY_DEF,
    parameter int PACKET_MAX     = phvts_pkg::PACKET_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  phvts_pkg::in_t    in_item,
    input  logic              queue_full,
    output logic              push,
    output phvts_pkg::op_t    push_item
);
    import phvts_pkg::*;

    localparam int CW = $clog2(PACKET_MAX + 2);
    localparam int TW = $clog2(TEXT_CAPACITY);
    localparam int XW = (CW > 17) ? CW : 17;

    logic [CW-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [7:0]    hdr_reg [HDR_BYTES];
    logic [TW-1:0] txt_cnt_reg, txt_cnt_next;
    logic [TW-1:0] trim_reg, trim_next;
    logic          ended_reg, ended_next;
    logic [2:0]    early_reg, early_next;
    logic [15:0]   hl_reg;
    logic [16:0]   hlt_reg;
    logic          hl_bad_reg;

    logic          accept;
    logic [7:0]    b;
    logic [15:0]   hl_raw, hl_c, tl_c;
    logic [16:0]   hlt_c;
    logic [31:0]   il_c, tot_c, cnt32;
    logic [XW-1:0] off_x, idx_x;
    logic [31:0]   txt32, idx32;
    logic [7:0]    c_san;
    logic          in_body, in_text, in_image;
    logic [2:0]    err;
    logic          full_hdr;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_item.rx_byte;

    assign hl_raw = {hdr_reg[21], hdr_reg[20]};
    assign hl_c   = (hl_raw == 16'd0) ? 16'(HDR_BYTES) : hl_raw;
    assign tl_c   = {hdr_reg[9], hdr_reg[8]};
    assign hlt_c  = 17'(hl_c) + 17'(tl_c);
    assign il_c   = {hdr_reg[19], hdr_reg[18], hdr_reg[17], hdr_reg[16]};
    assign tot_c  = {hdr_reg[7], hdr_reg[6], hdr_reg[5], hdr_reg[4]};

    assign off_x    = XW'(cnt_reg);
    assign idx_x    = off_x - XW'(hlt_reg);
    assign in_body  = (32'(cnt_reg) >= 32'(HDR_BYTES)) &&
                      (32'(cnt_reg) < 32'(PACKET_MAX)) && !hl_bad_reg;
    assign in_text  = in_body && (off_x >= XW'(hl_reg)) && (off_x < XW'(hlt_reg));
    assign in_image = in_body && (off_x >= XW'(hlt_reg)) &&
                      (33'(idx_x) < 33'(il_c)) && (33'(idx_x) < 33'(IMAGE_CAPACITY));
    assign c_san    = sanitize(b);
    assign txt32    = 32'(txt_cnt_reg);
    assign idx32    = 32'(idx_x);

    assign cnt_inc  = (32'(cnt_reg) <= 32'(PACKET_MAX)) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt32    = 32'(cnt_inc);
    assign full_hdr = cnt32 >= 32'(HDR_BYTES);

    always_comb begin
        txt_cnt_next = txt_cnt_reg;
        trim_next    = trim_reg;
        ended_next   = ended_reg;
        early_next   = early_reg;
        push_item    = '0;
        if (32'(cnt_reg) == 32'd1 && (hdr_reg[0] != MAGIC_0 || b != MAGIC_1)) begin
            early_next = ERR_MAGIC;
        end
        if (in_text && !ended_reg && txt_cnt_reg < TW'(TEXT_CAPACITY - 1)) begin
            if (b == 8'd0) begin
                ended_next = 1'b1;
            end else begin
                push_item.has_data   = 1'b1;
                push_item.data_kind  = KIND_TEXT;
                push_item.data_index = txt32[14:0];
                push_item.data_byte  = c_san;
                txt_cnt_next         = txt_cnt_reg + 1'b1;
                if (c_san != 8'd32) begin
                    trim_next = txt_cnt_reg + 1'b1;
                end
            end
        end else if (in_image) begin
            push_item.has_data   = 1'b1;
            push_item.data_kind  = KIND_IMAGE;
            push_item.data_index = idx32[14:0];
            push_item.data_byte  = b;
        end

        priority if (cnt32 > 32'(PACKET_MAX)) begin
            err = ERR_TOO_LARGE;
        end else if (!full_hdr) begin
            err = ERR_SHORT;
        end else if (early_reg != ERR_OK) begin
            err = early_reg;
        end else if (tot_c != cnt32) begin
            err = ERR_LENGTH;
        end else if (hl_c < 16'(HDR_BYTES) ||
                     (33'(hlt_c) + 33'(il_c)) > 33'(cnt32)) begin
            err = ERR_SECTIONS;
        end else begin
            err = ERR_OK;
        end

        push_item.has_status    = in_item.last_byte;
        push_item.error_code    = err;
        push_item.packet_length = (cnt32 > 32'd65535) ? 16'hFFFF : cnt32[15:0];
        if (full_hdr) begin
            push_item.peer_status  = hdr_reg[3];
            push_item.text_length  = 10'(32'(trim_next));
            push_item.image_width  = {hdr_reg[11], hdr_reg[10]};
            push_item.image_height = {hdr_reg[13], hdr_reg[12]};
            push_item.num_lines    = {hdr_reg[15], hdr_reg[14]};
            push_item.image_length = il_c;
        end
        cnt_next = cnt_inc;
        if (in_item.last_byte) begin
            cnt_next     = '0;
            txt_cnt_next = '0;
            trim_next    = '0;
            ended_next   = 1'b0;
            early_next   = ERR_OK;
        end
    end

    assign push = accept && (push_item.has_data || push_item.has_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            txt_cnt_reg <= '0;
            trim_reg    <= '0;
            ended_reg   <= 1'b0;
            early_reg   <= ERR_OK;
            hl_reg      <= 16'(HDR_BYTES);
            hlt_reg     <= '0;
            hl_bad_reg  <= 1'b0;
        end else if (accept) begin
            cnt_reg     <= cnt_next;
            txt_cnt_reg <= txt_cnt_next;
            trim_reg    <= trim_next;
            ended_reg   <= ended_next;
            early_reg   <= early_next;
            if (32'(cnt_reg) == 32'(HDR_BYTES - 1)) begin
                hl_reg     <= hl_c;
                hlt_reg    <= hlt_c;
                hl_bad_reg <= hl_c < 16'(HDR_BYTES);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && 32'(cnt_reg) < 32'(HDR_BYTES)) begin
            hdr_reg[cnt_reg[4:0]] <= b;
        end
    end

endmodule

>>> hw/rtl/phvts_queue.sv
module phvts_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  phvts_pkg::op_t push_item,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output phvts_pkg::op_t head
);
    import phvts_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    op_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   count_reg;

    assign full      = count_reg == (PW + 1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/phvts_back.sv
module phvts_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            not_empty,
    input  phvts_pkg::op_t  head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output phvts_pkg::out_t m_data
);
    import phvts_pkg::*;

    logic status_phase_reg;
    logic out_valid_reg;
    out_t out_reg;
    logic load;
    logic emit_data;
    out_t nxt;

    assign load      = not_empty && (!out_valid_reg || m_ready);
    assign emit_data = head.has_data && !status_phase_reg;
    assign pop       = load && !(emit_data && head.has_status);

    always_comb begin
        nxt = '0;
        if (emit_data) begin
            nxt.kind  = head.data_kind;
            nxt.index = head.data_index;
            nxt.data  = head.data_byte;
        end else begin
            nxt.kind          = KIND_STATUS;
            nxt.error_code    = head.error_code;
            nxt.peer_status   = head.peer_status;
            nxt.text_length   = head.text_length;
            nxt.image_width   = head.image_width;
            nxt.image_height  = head.image_height;
            nxt.num_lines     = head.num_lines;
            nxt.image_length  = head.image_length;
            nxt.packet_length = head.packet_length;
            nxt.last          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg    <= 1'b0;
            status_phase_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg    <= 1'b1;
            status_phase_reg <= !pop;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= nxt;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> hw/rtl/packet_header_validator_text_sanitizer.sv
// Packet header validator and text sanitizer.
// The s_ channel carries one packet byte per transfer, with last_byte set on
// the final byte. Bytes 0 to 23 form a little-endian header that is checked
// for magic, lengths and size. Text bytes are sanitized and sent as kind 0
// with their index; image bytes are sent as kind 1. The closing byte also
// produces a kind 2 status record with the error code and header fields.
// Data results are sent as their bytes arrive, whatever the error code.
// One byte is accepted per cycle while the queue is not full. Each result
// passes through the queue and then the output register before m_valid
// rises. A closing byte that also carries a data result yields two
// transfers on the m_ channel, so the output stage holds its queue entry
// for both; a four-entry queue between the classifier and the output
// stage absorbs that extra transfer while it has room. With input and
// output busy every cycle these can fill the queue, and s_ready then drops.
// When the receiver stalls, the output register holds its transfer, the
// queue fills, and s_ready drops once the queue is full.
// Reset empties the queue and clears all packet counters; the header bytes
// are rewritten by every packet of 24 bytes or more.
module packet_header_validator_text_sanitizer #(
    parameter int TEXT_CAPACITY  = phvts_pkg::TEXT_CAPACITY_DEF,
    parameter int IMAGE_CAPACITY = phvts_pkg::IMAGE_CAPACITY_DEF,
    parameter int PACKET_MAX     = phvts_pkg::PACKET_MAX_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  phvts_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output phvts_pkg::out_t m_data
);
    import phvts_pkg::*;

    logic full, not_empty, push, pop;
    op_t  push_item, head;

    phvts_front #(
        .TEXT_CAPACITY (TEXT_CAPACITY),
        .IMAGE_CAPACITY(IMAGE_CAPACITY),
        .PACKET_MAX    (PACKET_MAX)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .queue_full(full),
        .push      (push),
        .push_item (push_item)
    );

    phvts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .full     (full),
        .not_empty(not_empty),
        .pop      (pop),
        .head     (head)
    );

    phvts_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .not_empty(not_empty),
        .head     (head),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_last_on_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.kind == KIND_STATUS) == m_data.last))
        else $error("last must mark exactly the status record");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("queue written while full");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

>>> verif/tb_top.sv
module tb_top;
    import phvts_pkg::*;

    localparam int TCAP = TEXT_CAPACITY_DEF;
    localparam int ICAP = IMAGE_CAPACITY_DEF;
    localparam int PMAX = PACKET_MAX_DEF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    packet_header_validator_text_sanitizer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    in_t  byte_q[$];
    out_t result_q[$];
    int   tx_idle = 22;
    int   rx_idle = 73;
    int   mismatches = 0;
    int   packets = 0;
    int   bytes_in = 0;
    int   kind_seen[3] = '{0, 0, 0};

    int         byte_cnt = 0;
    logic [7:0] hdr[HDR_BYTES];
    int         txt_cnt = 0;
    int         trim_len = 0;
    bit         txt_end = 0;
    logic [2:0] early_err = ERR_OK;

    function automatic longint h16(int at);
        return 64'({hdr[at + 1], hdr[at]});
    endfunction

    function automatic longint h32(int at);
        return 64'({hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]});
    endfunction

    function automatic longint hdr_len();
        return h16(20) == 0 ? longint'(HDR_BYTES) : h16(20);
    endfunction

    function automatic logic [7:0] clean_char(logic [7:0] c);
        if (c == 8'd13 || c == 8'd10) begin
            return 8'd10;
        end
        if (c < 8'd32 || c > 8'd126) begin
            return 8'd32;
        end
        return c;
    endfunction

    function automatic void predict_byte(in_t it);
        logic [7:0] b = it.rx_byte;
        int         o = byte_cnt;
        out_t       r;
        longint     hl;
        longint     tl;
        longint     il;
        longint     off;
        logic [7:0] c;
        int         cnt;
        logic [2:0] err;
        if (o < HDR_BYTES) begin
            hdr[o] = b;
            if (o == 1 && (hdr[0] != MAGIC_0 || b != MAGIC_1)) begin
                early_err = ERR_MAGIC;
            end
        end else if (o < PMAX) begin
            hl = hdr_len();
            tl = h16(8);
            il = h32(16);
            off = o;
            if (hl >= HDR_BYTES) begin
                if (off >= hl && off - hl < tl) begin
                    if (!txt_end && txt_cnt < TCAP - 1) begin
                        if (b == 8'd0) begin
                            txt_end = 1;
                        end else begin
                            c = clean_char(b);
                            r = '0;
                            r.kind = KIND_TEXT;
                            r.index = 15'(txt_cnt);
                            r.data = c;
                            result_q.push_back(r);
                            txt_cnt++;
                            if (c != 8'd32) begin
                                trim_len = txt_cnt;
                            end
                        end
                    end
                end else if (off >= hl + tl && off - hl - tl < il) begin
                    if (off - hl - tl < ICAP) begin
                        r = '0;
                        r.kind = KIND_IMAGE;
                        r.index = 15'(off - hl - tl);
                        r.data = b;
                        result_q.push_back(r);
                    end
                end
            end
        end
        if (byte_cnt <= PMAX) begin
            byte_cnt++;
        end
        if (it.last_byte) begin
            cnt = byte_cnt;
            r = '0;
            r.kind = KIND_STATUS;
            if (cnt > PMAX) begin
                err = ERR_TOO_LARGE;
            end else if (cnt < HDR_BYTES) begin
                err = ERR_SHORT;
            end else if (early_err != ERR_OK) begin
                err = early_err;
            end else if (h32(4) != cnt) begin
                err = ERR_LENGTH;
            end else if (hdr_len() < HDR_BYTES || hdr_len() + h16(8) + h32(16) > cnt) begin
                err = ERR_SECTIONS;
            end else begin
                err = ERR_OK;
            end
            r.error_code = err;
            if (cnt >= HDR_BYTES) begin
                r.peer_status = hdr[3];
                r.text_length = 10'(trim_len);
                r.image_width = 16'(h16(10));
                r.image_height = 16'(h16(12));
                r.num_lines = 16'(h16(14));
                r.image_length = 32'(h32(16));
            end
            r.packet_length = 16'(cnt > 65535 ? 65535 : cnt);
            r.last = 1'b1;
            result_q.push_back(r);
            byte_cnt = 0;
            txt_cnt = 0;
            trim_len = 0;
            txt_end = 0;
            early_err = ERR_OK;
        end
    endfunction

    function automatic logic [7:0] text_byte(bit no_nul);
        int p = $urandom_range(99);
        if (p < 55) return 8'($urandom_range(126, 33));
        if (p < 67) return 8'd32;
        if (p < 72) return 8'd13;
        if (p < 77) return 8'd10;
        if (p < 82) return 8'd9;
        if (p < 95 || no_nul) return 8'($urandom_range(255, 1));
        return 8'd0;
    endfunction

    function automatic void add_packet(int n, bit magic_ok, int hl_field, int tl,
                                       logic [31:0] il, int len_adj, logic [7:0] st,
                                       bit no_nul);
        logic [7:0] h[HDR_BYTES];
        logic [31:0] total = n + len_adj;
        int hl_eff = hl_field == 0 ? HDR_BYTES : hl_field;
        in_t it;
        foreach (h[i]) h[i] = 8'($urandom);
        h[0] = MAGIC_0;
        h[1] = magic_ok ? MAGIC_1 : 8'($urandom_range(255, 87));
        h[3] = st;
        {h[7], h[6], h[5], h[4]} = total;
        {h[9], h[8]} = 16'(tl);
        {h[19], h[18], h[17], h[16]} = il;
        {h[21], h[20]} = 16'(hl_field);
        for (int i = 0; i < n; i++) begin
            if (i < HDR_BYTES) begin
                it.rx_byte = h[i];
            end else if (hl_field >= HDR_BYTES || hl_field == 0) begin
                it.rx_byte = (i >= hl_eff && i < hl_eff + tl) ? text_byte(no_nul)
                                                               : 8'($urandom);
            end else begin
                it.rx_byte = 8'($urandom);
            end
            it.last_byte = (i == n - 1);
            byte_q.push_back(it);
        end
        packets++;
    endfunction

    function automatic void add_random_packet();
        int p = $urandom_range(99);
        int hl = $urandom_range(1) ? 0 : $urandom_range(30, 24);
        int hle = hl == 0 ? HDR_BYTES : hl;
        int tl = $urandom_range(24);
        int il = $urandom_range(24);
        int n = hle + tl + il + $urandom_range(3);
        logic [7:0] st = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(2, 1));
        if (p < 70) begin
            add_packet(n, 1'b1, hl, tl, il, 0, st, 1'b0);
        end else if (p < 75) begin
            add_packet(n, 1'b0, hl, tl, il, 0, st, 1'b0);
        end else if (p < 80) begin
            add_packet(n, 1'b1, hl, tl, il, $urandom_range(1) ? 1 : -1, st, 1'b0);
        end else if (p < 85) begin
            add_packet(n, 1'b1, hl, tl + 40, il, 0, st, 1'b0);
        end else if (p < 90) begin
            add_packet(n, 1'b1, $urandom_range(23, 1), tl, il, 0, st, 1'b0);
        end else if (p < 95) begin
            add_packet($urandom_range(23, 1), 1'b1, hl, tl, il, 0, st, 1'b0);
        end else begin
            add_packet($urandom_range(40, 1), 1'($urandom_range(1)), $urandom,
                       $urandom_range(60), $urandom, $urandom_range(20), 8'($urandom),
                       1'b0);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (byte_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                s_valid <= 1'b1;
                s_data <= byte_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= rx_idle;
            if (s_valid && s_ready) begin
                predict_byte(s_data);
                bytes_in++;
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected transfer: %h", m_data);
                    end
                end else begin
                    if (m_data !== result_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %h, actual %h", result_q[0], m_data);
                        end
                    end
                    if (result_q[0].kind <= KIND_STATUS) begin
                        kind_seen[result_q[0].kind]++;
                    end
                    void'(result_q.pop_front());
                end
            end
        end
    end

    task automatic drain();
        while (byte_q.size() > 0 || s_valid || result_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        add_packet(1, 1'b1, 0, 0, 32'd0, 0, 8'd1, 1'b0);
        add_packet(23, 1'b1, 0, 0, 32'd0, 0, 8'd1, 1'b0);
        add_packet(24, 1'b1, 0, 0, 32'd0, 0, 8'd0, 1'b0);
        add_packet(40, 1'b0, 0, 8, 32'd8, 0, 8'd1, 1'b0);
        add_packet(40, 1'b1, 0, 8, 32'd8, 1, 8'd2, 1'b0);
        add_packet(40, 1'b1, 10, 8, 32'd8, 0, 8'd1, 1'b0);
        add_packet(29, 1'b1, 0, 10, 32'd0, 0, 8'd1, 1'b0);
        add_packet(30, 1'b1, 0, 2, 32'hFFFF_FFFF, 0, 8'd255, 1'b0);
        repeat (2) add_random_packet();
        drain();

        tx_idle = 73;
        rx_idle = 22;
        repeat (2) add_random_packet();
        drain();

        tx_idle = 0;
        rx_idle = 0;
        add_packet(24 + 1030, 1'b1, 0, 1030, 32'd0, 0, 8'd1, 1'b1);
        add_random_packet();
        drain();

        if (result_q.size() > 0) mismatches++;
        $display("Sent %0d packets in %0d byte transfers.", packets, bytes_in);
        $display("Checked %0d text, %0d image and %0d status transfers.",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
